@@ rtl/tx_wire_format_parser_macros.svh @@
// Assertion macros for the transaction wire-format parser checker.
// Included by the checker file only.
`ifndef TX_WIRE_FORMAT_PARSER_MACROS_SVH
`define TX_WIRE_FORMAT_PARSER_MACROS_SVH
// assert that a implies b on the next edge
`define TWF_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lbl failed");
// assert that a implies b on the same edge
`define TWF_SAME(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lbl failed");
`endif

@@ rtl/twfp_pkg.sv @@
// Package for the transaction wire-format parser: field codes, phases, sizes.
// No dependencies.
`default_nettype none
package twfp_pkg;
    localparam int HASH_BYTES = 32;
    localparam int COUNT_BITS = 32;

    localparam logic [3:0] K_VERSION  = 4'd0;
    localparam logic [3:0] K_IN_COUNT = 4'd1;
    localparam logic [3:0] K_PREV_HASH = 4'd2;
    localparam logic [3:0] K_PREV_IDX = 4'd3;
    localparam logic [3:0] K_IN_ASSET = 4'd4;
    localparam logic [3:0] K_SIG_LEN  = 4'd5;
    localparam logic [3:0] K_SIG_BYTE = 4'd6;
    localparam logic [3:0] K_SEQUENCE = 4'd7;
    localparam logic [3:0] K_OUT_COUNT = 4'd8;
    localparam logic [3:0] K_OUT_ASSET = 4'd9;
    localparam logic [3:0] K_VALUE    = 4'd10;
    localparam logic [3:0] K_PK_LEN   = 4'd11;
    localparam logic [3:0] K_PK_BYTE  = 4'd12;
    localparam logic [3:0] K_LOCK     = 4'd13;
    localparam logic [3:0] K_DONE     = 4'd14;

    localparam logic [1:0] S_BUSY     = 2'd0;
    localparam logic [1:0] S_COMPLETE = 2'd1;
    localparam logic [1:0] S_TRUNC    = 2'd2;
    localparam logic [1:0] S_TRAIL    = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  pos;
        logic [31:0] ent;
        logic [63:0] val;
        logic        comp;
        logic [1:0]  status;
    } t_result;

    function automatic logic [5:0] field_width(input logic [3:0] k);
        case (k)
            K_PREV_HASH: field_width = 6'(HASH_BYTES);
            K_IN_ASSET, K_OUT_ASSET: field_width = 6'd1;
            K_VALUE: field_width = 6'd8;
            default: field_width = 6'd4;
        endcase
    endfunction
endpackage
`default_nettype wire

@@ rtl/tx_wire_format_parser.sv @@
// Transaction wire-format parser top level: tagging stage and result queue.
// Depends on twfp_pkg, twfp_front, twfp_fifo.
//
// Usage: push one byte per cycle on i_byte_value with i_is_last marking the
// buffer's final byte; a byte is taken when i_push is high and o_full low.
// Each byte yields one result: field kind, byte position, entry number,
// field value (completed little-endian number on a field's final byte,
// except hash, asset and script data), completion flag and parse status.
// Results are read queue-style: while o_empty is low the oldest result is on
// the output ports and i_pop takes it. o_empty falls in the cycle after an
// accept; throughput is one byte per cycle while o_full is low. A four-entry
// result queue absorbs receiver stalls; o_full rises when it fills and input
// halts without loss. Synchronous reset returns the parser to the version
// field and empties the queue; it also restarts after each last byte.
`default_nettype none
module tx_wire_format_parser import twfp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_is_last,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [3:0]       o_field_kind,
    output logic [4:0]       o_byte_in_field,
    output logic [31:0]      o_entry_number,
    output logic [63:0]      o_field_value,
    output logic             o_field_complete,
    output logic [1:0]       o_parse_status
);
    t_result w_res, w_out;
    logic    w_acc;

    assign w_acc = i_push && !o_full;

    twfp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_acc),
        .i_byte_value(i_byte_value), .i_is_last(i_is_last), .o_result(w_res)
    );

    twfp_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_acc), .i_data(w_res),
        .o_full(o_full), .i_pop(i_pop), .o_empty(o_empty), .o_data(w_out)
    );

    assign o_field_kind     = w_out.kind;
    assign o_byte_in_field  = w_out.pos;
    assign o_entry_number   = w_out.ent;
    assign o_field_value    = w_out.val;
    assign o_field_complete = w_out.comp;
    assign o_parse_status   = w_out.status;
endmodule
`default_nettype wire

@@ rtl/twfp_front.sv @@
// Front stage: tracks the field state machine and tags each accepted byte.
// Depends on twfp_pkg.
`default_nettype none
module twfp_front import twfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_is_last,
    output t_result         o_result
);
    localparam logic [31:0] CMAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    logic [3:0]  r_phase, n_phase;
    logic [5:0]  r_fbc, n_fbc;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_sleft, n_sleft;
    logic [31:0] r_eleft, n_eleft;
    logic [31:0] r_ecnt, n_ecnt;
    logic        r_err, n_err;

    always_comb begin
        logic [63:0] v;
        logic [31:0] sl;
        logic [31:0] nsat;
        logic        endent;
        logic [3:0]  efirst, eafter;
        n_phase = r_phase; n_fbc = r_fbc; n_acc = r_acc; n_sleft = r_sleft;
        n_eleft = r_eleft; n_ecnt = r_ecnt; n_err = r_err;
        o_result = '0;
        o_result.kind = K_LOCK;
        o_result.val = {56'd0, i_byte_value};
        v = r_acc;
        sl = r_sleft;
        endent = 1'b0;
        efirst = K_PREV_HASH;
        eafter = K_OUT_COUNT;
        nsat = '0;
        if (r_phase > K_LOCK) begin
            n_phase = K_DONE;
            n_err = 1'b1;
        end else begin
            o_result.kind = r_phase;
            if ((r_phase >= K_PREV_HASH && r_phase <= K_SEQUENCE)
                    || (r_phase >= K_OUT_ASSET && r_phase <= K_PK_BYTE))
                o_result.ent = r_ecnt;
            if (r_phase == K_SIG_BYTE || r_phase == K_PK_BYTE) begin
                if (sl != 32'd0) sl = sl - 32'd1;
                n_sleft = sl;
                if (sl == 32'd0) begin
                    o_result.comp = 1'b1;
                    if (r_phase == K_SIG_BYTE) n_phase = K_SEQUENCE;
                    else begin
                        endent = 1'b1; efirst = K_OUT_ASSET; eafter = K_LOCK;
                    end
                end
            end else begin
                o_result.pos = r_fbc[4:0];
                if (r_fbc < 6'd8)
                    v = r_acc | ({56'd0, i_byte_value} << {r_fbc[2:0], 3'b000});
                n_acc = v;
                n_fbc = r_fbc + 6'd1;
                if (n_fbc >= field_width(r_phase)) begin
                    o_result.comp = 1'b1;
                    if (r_phase != K_PREV_HASH && r_phase != K_IN_ASSET
                            && r_phase != K_OUT_ASSET)
                        o_result.val = v;
                    n_fbc = '0;
                    n_acc = '0;
                    nsat = (v[63:32] != 32'd0 || v[31:0] > CMAX) ? CMAX : v[31:0];
                    case (r_phase)
                        K_VERSION: n_phase = K_IN_COUNT;
                        K_IN_COUNT: begin
                            n_eleft = nsat; n_ecnt = '0;
                            n_phase = (nsat != 32'd0) ? K_PREV_HASH : K_OUT_COUNT;
                        end
                        K_PREV_HASH: n_phase = K_PREV_IDX;
                        K_PREV_IDX: n_phase = K_IN_ASSET;
                        K_IN_ASSET: n_phase = K_SIG_LEN;
                        K_SIG_LEN: begin
                            n_sleft = v[31:0];
                            n_phase = (v[31:0] != 32'd0) ? K_SIG_BYTE : K_SEQUENCE;
                        end
                        K_SEQUENCE: endent = 1'b1;
                        K_OUT_COUNT: begin
                            n_eleft = nsat; n_ecnt = '0;
                            n_phase = (nsat != 32'd0) ? K_OUT_ASSET : K_LOCK;
                        end
                        K_OUT_ASSET: n_phase = K_VALUE;
                        K_VALUE: n_phase = K_PK_LEN;
                        K_PK_LEN: begin
                            n_sleft = v[31:0];
                            if (v[31:0] != 32'd0) n_phase = K_PK_BYTE;
                            else begin
                                endent = 1'b1; efirst = K_OUT_ASSET; eafter = K_LOCK;
                            end
                        end
                        default: n_phase = K_DONE;
                    endcase
                end
            end
            if (endent) begin
                n_ecnt = (r_ecnt + 32'd1) & CMAX;
                if (r_eleft <= 32'd1) begin
                    n_eleft = '0; n_ecnt = '0; n_phase = eafter;
                end else begin
                    n_eleft = r_eleft - 32'd1; n_phase = efirst;
                end
            end
        end
        if (i_is_last) begin
            if (n_err) o_result.status = S_TRAIL;
            else o_result.status = (n_phase == K_DONE) ? S_COMPLETE : S_TRUNC;
        end else begin
            o_result.status = n_err ? S_TRAIL : S_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_is_last)) begin
            r_phase <= K_VERSION; r_fbc <= '0; r_acc <= '0; r_sleft <= '0;
            r_eleft <= '0; r_ecnt <= '0; r_err <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase; r_fbc <= n_fbc; r_acc <= n_acc;
            r_sleft <= n_sleft; r_eleft <= n_eleft; r_ecnt <= n_ecnt;
            r_err <= n_err;
        end
    end
endmodule
`default_nettype wire

@@ rtl/twfp_fifo.sv @@
// Result queue between the tagging stage and the output port.
// Depends on twfp_pkg.
`default_nettype none
module twfp_fifo import twfp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_result   o_data
);
    t_result    r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_push} - {2'd0, w_pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/twfp_checker.sv @@
// Port-level checker for the parser, bound to the top level.
// Depends on twfp_pkg and tx_wire_format_parser_macros.svh.
`default_nettype none
`include "tx_wire_format_parser_macros.svh"
module twfp_checker import twfp_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_push,
    input wire logic       i_pop,
    input wire logic       o_full,
    input wire logic       o_empty,
    input wire logic [3:0] o_field_kind,
    input wire logic [1:0] o_parse_status,
    input wire logic       o_field_complete
);
    `TWF_SAME(a_not_both, i_clk, i_rst_n, 1'b1, !(o_full && o_empty))
    `TWF_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !o_full, !o_empty)
    `TWF_SAME(a_kind_range, i_clk, i_rst_n, !o_empty, o_field_kind <= K_LOCK)
    `TWF_SAME(a_done_lock, i_clk, i_rst_n,
        !o_empty && o_parse_status == S_COMPLETE, o_field_kind == K_LOCK && o_field_complete)
endmodule
bind tx_wire_format_parser twfp_checker u_twfp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_pop(i_pop),
    .o_full(o_full), .o_empty(o_empty), .o_field_kind(o_field_kind),
    .o_parse_status(o_parse_status), .o_field_complete(o_field_complete)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for tx_wire_format_parser: streams serialized transactions and checks each tag.
// Depends on twfp_pkg and the parser RTL; a behavioral tagger predicts every result.
`default_nettype none
module tb_top;
    import twfp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic [7:0]  i_byte_value;
    logic        i_is_last;
    logic        i_pop;
    logic        o_full;
    logic        o_empty;
    logic [3:0]  o_field_kind;
    logic [4:0]  o_byte_in_field;
    logic [31:0] o_entry_number;
    logic [63:0] o_field_value;
    logic        o_field_complete;
    logic [1:0]  o_parse_status;

    tx_wire_format_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_byte_value(i_byte_value), .i_is_last(i_is_last), .o_empty(o_empty),
        .i_pop(i_pop), .o_field_kind(o_field_kind), .o_byte_in_field(o_byte_in_field),
        .o_entry_number(o_entry_number), .o_field_value(o_field_value),
        .o_field_complete(o_field_complete), .o_parse_status(o_parse_status)
    );

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] COUNT_TOP = 32'((64'd1 << COUNT_BITS) - 1);

    logic [3:0]  tag_phase;
    logic [5:0]  tag_pos;
    logic [63:0] tag_acc;
    logic [31:0] tag_script_left;
    logic [31:0] tag_entries_left;
    logic [31:0] tag_entry;
    logic        tag_trailing;

    t_result expected_tags[$];
    int  error_count;
    int  idle_cycles;
    bit  gaps_on;
    bit  sink_hold;
    bit  sink_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [5:0] kind_width(input logic [3:0] k);
        case (k)
            K_PREV_HASH: return 6'(HASH_BYTES);
            K_IN_ASSET, K_OUT_ASSET: return 6'd1;
            K_VALUE: return 6'd8;
            default: return 6'd4;
        endcase
    endfunction

    function automatic logic [31:0] clamp_count(input logic [63:0] v);
        return (v > 64'(COUNT_TOP)) ? COUNT_TOP : v[31:0];
    endfunction

    task automatic close_entry(input logic [3:0] first, input logic [3:0] after);
        tag_entry = (tag_entry + 32'd1) & COUNT_TOP;
        if (tag_entries_left <= 32'd1) begin
            tag_entries_left = '0;
            tag_entry = '0;
            tag_phase = after;
        end else begin
            tag_entries_left--;
            tag_phase = first;
        end
    endtask

    task automatic step_phase(input logic [3:0] k, input logic [63:0] v);
        logic [31:0] n;
        case (k)
            K_VERSION: tag_phase = K_IN_COUNT;
            K_IN_COUNT, K_OUT_COUNT: begin
                n = clamp_count(v);
                tag_entries_left = n;
                tag_entry = '0;
                if (k == K_IN_COUNT) tag_phase = (n != 0) ? K_PREV_HASH : K_OUT_COUNT;
                else tag_phase = (n != 0) ? K_OUT_ASSET : K_LOCK;
            end
            K_PREV_HASH: tag_phase = K_PREV_IDX;
            K_PREV_IDX: tag_phase = K_IN_ASSET;
            K_IN_ASSET: tag_phase = K_SIG_LEN;
            K_SIG_LEN: begin
                tag_script_left = v[31:0];
                tag_phase = (v[31:0] != 0) ? K_SIG_BYTE : K_SEQUENCE;
            end
            K_SIG_BYTE: tag_phase = K_SEQUENCE;
            K_SEQUENCE: close_entry(K_PREV_HASH, K_OUT_COUNT);
            K_OUT_ASSET: tag_phase = K_VALUE;
            K_VALUE: tag_phase = K_PK_LEN;
            K_PK_LEN: begin
                tag_script_left = v[31:0];
                if (v[31:0] != 0) tag_phase = K_PK_BYTE;
                else close_entry(K_OUT_ASSET, K_LOCK);
            end
            K_PK_BYTE: close_entry(K_OUT_ASSET, K_LOCK);
            default: tag_phase = K_DONE;
        endcase
    endtask

    task automatic clear_tagger();
        tag_phase = K_VERSION;
        tag_pos = '0;
        tag_acc = '0;
        tag_script_left = '0;
        tag_entries_left = '0;
        tag_entry = '0;
        tag_trailing = 1'b0;
    endtask

    task automatic tag_byte(input logic [7:0] b, input logic last);
        t_result r;
        logic [63:0] v;
        r = '0;
        r.kind = K_LOCK;
        r.val = 64'(b);
        if (tag_phase > K_LOCK) begin
            tag_phase = K_DONE;
            tag_trailing = 1'b1;
        end else begin
            r.kind = tag_phase;
            if ((tag_phase >= K_PREV_HASH && tag_phase <= K_SEQUENCE) ||
                (tag_phase >= K_OUT_ASSET && tag_phase <= K_PK_BYTE))
                r.ent = tag_entry;
            if (tag_phase == K_SIG_BYTE || tag_phase == K_PK_BYTE) begin
                if (tag_script_left > 0) tag_script_left--;
                if (tag_script_left == 0) begin
                    r.comp = 1'b1;
                    step_phase(r.kind, 64'd0);
                end
            end else begin
                r.pos = tag_pos[4:0];
                if (tag_pos < 8) tag_acc |= 64'(b) << (8 * tag_pos);
                tag_pos++;
                if (tag_pos >= kind_width(r.kind)) begin
                    v = tag_acc;
                    r.comp = 1'b1;
                    if (r.kind != K_PREV_HASH && r.kind != K_IN_ASSET &&
                        r.kind != K_OUT_ASSET)
                        r.val = v;
                    tag_pos = '0;
                    tag_acc = '0;
                    step_phase(r.kind, v);
                end
            end
        end
        if (tag_trailing) r.status = S_TRAIL;
        else if (last) r.status = (tag_phase == K_DONE) ? S_COMPLETE : S_TRUNC;
        else r.status = S_BUSY;
        expected_tags = {expected_tags, r};
        if (last) clear_tagger();
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (gaps_on && $urandom_range(99) < 31) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_byte_value <= b;
        i_is_last <= last;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        tag_byte(b, last);
    endtask

    task automatic send_word(input logic [63:0] v, input int nbytes, input logic last);
        for (int i = 0; i < nbytes; i++)
            send_byte(v[8 * i +: 8], last && (i == nbytes - 1));
    endtask

    // Serialize a well-formed transaction, then extra bytes; cut_at >= 0 ends it there.
    task automatic send_transaction(input int n_in, input int n_out, input int max_script,
                                    input int cut_at, input int extra);
        logic [7:0] stream[$];
        logic [31:0] len;
        logic [63:0] w;
        int total;
        for (int i = 0; i < 4; i++) stream = {stream, 8'($urandom)};
        for (int i = 0; i < 4; i++) stream = {stream, 8'(n_in >> (8 * i))};
        for (int e = 0; e < n_in; e++) begin
            for (int i = 0; i < HASH_BYTES; i++) stream = {stream, 8'($urandom)};
            for (int i = 0; i < 5; i++) stream = {stream, 8'($urandom)};
            len = $urandom_range(max_script);
            for (int i = 0; i < 4; i++) stream = {stream, len[8 * i +: 8]};
            for (int i = 0; i < len; i++) stream = {stream, 8'($urandom)};
            for (int i = 0; i < 4; i++) stream = {stream, 8'($urandom)};
        end
        for (int i = 0; i < 4; i++) stream = {stream, 8'(n_out >> (8 * i))};
        for (int e = 0; e < n_out; e++) begin
            w = {$urandom, $urandom};
            stream = {stream, 8'($urandom)};
            for (int i = 0; i < 8; i++) stream = {stream, w[8 * i +: 8]};
            len = $urandom_range(max_script);
            for (int i = 0; i < 4; i++) stream = {stream, len[8 * i +: 8]};
            for (int i = 0; i < len; i++) stream = {stream, 8'($urandom)};
        end
        for (int i = 0; i < 4 + extra; i++) stream = {stream, 8'($urandom)};
        total = (cut_at >= 0 && cut_at < stream.size()) ? cut_at + 1 : stream.size();
        for (int i = 0; i < total; i++) send_byte(stream[i], i == total - 1);
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (expected_tags.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_minimal_and_extremes();
        send_word(64'hFFFF_FFFF, 4, 0);
        send_word(64'd0, 4, 0);
        send_word(64'd0, 4, 0);
        send_word(64'hFFFF_FFFF, 4, 1);
        send_word(64'd0, 4, 0);
        send_word(64'd0, 3, 1);
        send_byte(8'hFF, 1);
        send_byte(8'h00, 1);
    endtask

    task automatic test_large_count();
        send_word(64'd1, 4, 0);
        send_word(64'hFFFF_FFFF, 4, 0);
        send_word(64'hA5, 6, 1);
    endtask

    task automatic test_trailing_data();
        send_transaction(1, 1, 2, -1, 3);
        send_transaction(0, 0, 0, -1, 1);
    endtask

    task automatic test_back_pressure();
        sink_hold = 1;
        fork
            begin
                repeat (60) @(posedge i_clk);
                sink_hold = 0;
            end
            send_transaction(1, 1, 3, -1, 0);
        join
        wait_drained();
    endtask

    task automatic test_random_streams();
        int kind;
        for (int t = 0; t < 12; t++) begin
            gaps_on = (t < 4 || t > 6);
            sink_gaps = gaps_on;
            kind = $urandom_range(9);
            if (kind < 7) send_transaction($urandom_range(2), $urandom_range(2), 4, -1, 0);
            else if (kind == 7)
                send_transaction($urandom_range(2), $urandom_range(2), 4,
                                 $urandom_range(80), 0);
            else if (kind == 8)
                send_transaction($urandom_range(1), $urandom_range(1), 3, -1,
                                 $urandom_range(4, 1));
            else
                for (int i = 0; i < 8; i++) send_byte(8'($urandom), i == 7);
        end
        gaps_on = 1;
        sink_gaps = 1;
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_tags.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_field_kind), 64'd0);
            end else begin
                w = expected_tags.pop_front();
                if (o_field_kind !== w.kind)
                    report_mismatch("kind", 64'(o_field_kind), 64'(w.kind));
                if (o_byte_in_field !== w.pos)
                    report_mismatch("pos", 64'(o_byte_in_field), 64'(w.pos));
                if (o_entry_number !== w.ent)
                    report_mismatch("entry", 64'(o_entry_number), 64'(w.ent));
                if (o_field_value !== w.val) report_mismatch("value", o_field_value, w.val);
                if (o_field_complete !== w.comp)
                    report_mismatch("complete", 64'(o_field_complete), 64'(w.comp));
                if (o_parse_status !== w.status)
                    report_mismatch("status", 64'(o_parse_status), 64'(w.status));
            end
        end
        i_pop <= i_rst_n && !sink_hold && !(sink_gaps && $urandom_range(99) < 31);
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_byte_value = '0;
        i_is_last = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        gaps_on = 1;
        sink_hold = 0;
        sink_gaps = 1;
        clear_tagger();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_minimal_and_extremes();
        test_large_count();
        test_trailing_data();
        wait_drained();
        test_back_pressure();
        test_random_streams();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_tags.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
